// ----- rtl/decimal_mid_square_key_hash_core_macros.svh -----
// Assertion macros shared by the checker files of the mid-square key hash.
// Depends on nothing; every macro expands to one labelled concurrent assertion.
`ifndef DECIMAL_MID_SQUARE_KEY_HASH_CORE_MACROS_SVH
`define DECIMAL_MID_SQUARE_KEY_HASH_CORE_MACROS_SVH

// Overlapping implication, checked outside reset.
`define DMSK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmsk assertion failed");

// Non-overlapping implication, checked in the next cycle, outside reset.
`define DMSK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmsk assertion failed");

`endif

// ----- rtl/dmsk_pkg.sv -----
// Shared types and constants of the decimal mid-square key hash.
// Depends on nothing; the unit, core and checker files refer to it by scoped names.
package dmsk_pkg;

    localparam int TL_W       = 31;
    localparam int IDX_W      = 30;
    localparam int SUM_W      = 16;
    localparam int SQ_BITS    = 31;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int MAX_POW    = 9;

    localparam logic [SUM_W-1:0] SUM_LIMIT    = 16'd46340;
    localparam logic [TL_W-1:0]  TL_RESET     = 31'd16;
    localparam logic [TL_W-1:0]  TL_TWO_DIGIT = 31'd100;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] index_value;
        logic             sum_saturated;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SQUARE  = 5'b00010,
        ST_CONVERT = 5'b00100,
        ST_PICK    = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic               done;
        logic [SQ_BITS-1:0] square;
        logic [3:0]         extra;
    } sq_stat_t;

    typedef struct packed {
        logic                done;
        logic [BCD_BITS-1:0] digits;
        logic [3:0]          ndig;
    } bcd_stat_t;

    typedef struct packed {
        logic [3:0] first;
        logic [3:0] last;
    } pick_plan_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] value;
    } pick_stat_t;

    function automatic logic [TL_W-1:0] pow10(input logic [3:0] k);
        logic [TL_W-1:0] p;
        case (k)
            4'd0:    p = 31'd1;
            4'd1:    p = 31'd10;
            4'd2:    p = 31'd100;
            4'd3:    p = 31'd1000;
            4'd4:    p = 31'd10000;
            4'd5:    p = 31'd100000;
            4'd6:    p = 31'd1000000;
            4'd7:    p = 31'd10000000;
            4'd8:    p = 31'd100000000;
            4'd9:    p = 31'd1000000000;
            default: p = 31'h7FFFFFFF;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/dmsk_square_unit.sv -----
// Bit-serial squarer (one multiplier bit per cycle) that also counts the
// decimal digits of the table length less one, one power of ten per cycle.
// Depends on dmsk_pkg.
module dmsk_square_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dmsk_pkg::SUM_W-1:0]     operand,
    input  logic [dmsk_pkg::TL_W-1:0]      table_length,
    output dmsk_pkg::sq_stat_t             stat
);

    logic [dmsk_pkg::SUM_W-1:0]   a_reg;
    logic [dmsk_pkg::SUM_W-1:0]   b_reg;
    logic [dmsk_pkg::SQ_BITS-1:0] p_reg;
    logic [3:0]                   cnt_reg;
    logic [3:0]                   extra_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [dmsk_pkg::SQ_BITS-1:0] addend;
    logic                         pow_hit;

    assign addend  = b_reg[dmsk_pkg::SUM_W-1]
                   ? {{(dmsk_pkg::SQ_BITS-dmsk_pkg::SUM_W){1'b0}}, a_reg}
                   : '0;
    assign pow_hit = (cnt_reg >= 4'd1) && (cnt_reg <= 4'(dmsk_pkg::MAX_POW))
                   && (table_length >= dmsk_pkg::pow10(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'(dmsk_pkg::SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(dmsk_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Partial products never exceed the square, so 31 bits never overflow.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg     <= operand;
            b_reg     <= operand;
            p_reg     <= '0;
            extra_reg <= '0;
        end
        else if (busy_reg)
        begin
            p_reg <= {p_reg[dmsk_pkg::SQ_BITS-2:0], 1'b0} + addend;
            b_reg <= {b_reg[dmsk_pkg::SUM_W-2:0], 1'b0};
            if (pow_hit)
            begin
                extra_reg <= extra_reg + 4'd1;
            end
        end
    end

    assign stat.done   = done_reg;
    assign stat.square = p_reg;
    assign stat.extra  = extra_reg;

endmodule

// ----- rtl/dmsk_bcd_unit.sv -----
// Bit-serial binary to decimal converter (shift and add three), followed by
// a digit-serial pass that strips leading zero digits.
// Depends on dmsk_pkg.
module dmsk_bcd_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dmsk_pkg::SQ_BITS-1:0]   value,
    output dmsk_pkg::bcd_stat_t            stat
);

    logic [dmsk_pkg::SQ_BITS-1:0]  h_reg;
    logic [dmsk_pkg::BCD_BITS-1:0] bcd_reg;
    logic [dmsk_pkg::BCD_BITS-1:0] adj;
    logic [4:0]                    cnt_reg;
    logic [3:0]                    lz_reg;
    logic                          dab_reg;
    logic                          norm_reg;
    logic                          done_reg;
    logic                          norm_shift;

    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < dmsk_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    assign norm_shift = (bcd_reg[dmsk_pkg::BCD_BITS-1 -: 4] == 4'd0)
                      && (lz_reg < 4'(dmsk_pkg::NUM_DIGITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dab_reg  <= 1'b0;
            norm_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dab_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (dab_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(dmsk_pkg::SQ_BITS - 1))
                begin
                    dab_reg  <= 1'b0;
                    norm_reg <= 1'b1;
                end
            end
            else if (norm_reg && !norm_shift)
            begin
                norm_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // After normalising, digit 0 sits at the top and zeros fill in behind.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg   <= value;
            bcd_reg <= '0;
            lz_reg  <= '0;
        end
        else if (dab_reg)
        begin
            bcd_reg <= {adj[dmsk_pkg::BCD_BITS-2:0], h_reg[dmsk_pkg::SQ_BITS-1]};
            h_reg   <= {h_reg[dmsk_pkg::SQ_BITS-2:0], 1'b0};
        end
        else if (norm_reg && norm_shift)
        begin
            bcd_reg <= {bcd_reg[dmsk_pkg::BCD_BITS-5:0], 4'd0};
            lz_reg  <= lz_reg + 4'd1;
        end
    end

    assign stat.done   = done_reg;
    assign stat.digits = bcd_reg;
    assign stat.ndig   = 4'(dmsk_pkg::NUM_DIGITS) - lz_reg;

endmodule

// ----- rtl/dmsk_digit_pick.sv -----
// Digit-serial selector: walks the decimal digits one per cycle and folds
// those in the chosen window into a binary value (times ten plus digit).
// Depends on dmsk_pkg.
module dmsk_digit_pick (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dmsk_pkg::BCD_BITS-1:0]   digits,
    input  dmsk_pkg::pick_plan_t            plan,
    output dmsk_pkg::pick_stat_t            stat
);

    logic [dmsk_pkg::BCD_BITS-1:0] dig_reg;
    logic [dmsk_pkg::IDX_W-1:0]    acc_reg;
    logic [3:0]                    first_reg;
    logic [3:0]                    last_reg;
    logic [3:0]                    pos_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          finish;
    logic [dmsk_pkg::IDX_W-1:0]    acc_times_ten;

    assign finish        = busy_reg && (pos_reg == last_reg - 4'd1);
    assign acc_times_ten = {acc_reg[dmsk_pkg::IDX_W-4:0], 3'b000}
                         + {acc_reg[dmsk_pkg::IDX_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dig_reg   <= digits;
            first_reg <= plan.first;
            last_reg  <= plan.last;
            pos_reg   <= '0;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (pos_reg >= first_reg)
            begin
                acc_reg <= acc_times_ten
                         + {{(dmsk_pkg::IDX_W-4){1'b0}}, dig_reg[dmsk_pkg::BCD_BITS-1 -: 4]};
            end
            dig_reg <= {dig_reg[dmsk_pkg::BCD_BITS-5:0], 4'd0};
            pos_reg <= pos_reg + 4'd1;
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = acc_reg;

endmodule

// ----- rtl/decimal_mid_square_key_hash_core.sv -----
// Decimal mid-square key hash: key bytes are summed one per cycle while the
// input is not stalled (the sum clamps at 46340), and a byte marked last
// closes the key. Only a last byte starts work: the sum is squared
// bit-serially, converted to ten decimal digits bit-serially, stripped of
// leading zeros and reduced to the middle-digit index, and a key's closing
// byte holds the input stalled until the index is loaded into the output
// register. The result sits in that register, so the next key may start
// while it waits to be taken.
module decimal_mid_square_key_hash_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dmsk_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dmsk_pkg::out_word_t            out_data,
    input  logic                           cfg_we,
    input  logic [dmsk_pkg::TL_W-1:0]      cfg_wdata
);

    dmsk_pkg::state_t              state_reg;
    dmsk_pkg::state_t              state_next;
    logic [dmsk_pkg::TL_W-1:0]     tl_reg;
    logic [dmsk_pkg::SUM_W-1:0]    sum_reg;
    logic [dmsk_pkg::SUM_W-1:0]    sum_next;
    logic                          sat_reg;
    logic                          sat_next;
    logic                          job_sat_reg;
    logic                          h_odd_reg;
    logic                          tl_le_100_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    dmsk_pkg::out_word_t           out_data_reg;
    logic                          accept;
    logic                          key_end;
    logic                          emit_load;
    logic [dmsk_pkg::SUM_W:0]      sum_wide;
    logic [dmsk_pkg::SUM_W-1:0]    sum_clamped;
    logic                          clamp;
    dmsk_pkg::sq_stat_t            sq_stat;
    dmsk_pkg::bcd_stat_t           bcd_stat;
    dmsk_pkg::pick_stat_t          pick_stat;
    dmsk_pkg::pick_plan_t          plan;
    logic [3:0]                    mid;
    logic [3:0]                    first;
    logic [3:0]                    count;

    assign accept      = in_valid && !in_stall;
    assign key_end     = accept && in_data.last_byte;
    assign sum_wide    = {1'b0, sum_reg} + {{(dmsk_pkg::SUM_W-7){1'b0}}, in_data.key_byte};
    assign clamp       = sum_wide > {1'b0, dmsk_pkg::SUM_LIMIT};
    assign sum_clamped = clamp ? dmsk_pkg::SUM_LIMIT : sum_wide[dmsk_pkg::SUM_W-1:0];
    assign emit_load   = (state_reg == dmsk_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);

    dmsk_square_unit u_square (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (key_end),
        .operand      (sum_clamped),
        .table_length (tl_reg),
        .stat         (sq_stat)
    );

    dmsk_bcd_unit u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_stat.done),
        .value (sq_stat.square),
        .stat  (bcd_stat)
    );

    // An even square takes the digit at D/2. An odd one takes the digit at (D-1)/2
    // for a table length below 10, else a window as wide as the length has digits
    // less one, from (D-1)/2 up to length 100 and from half that width above.
    always_comb
    begin
        mid = (bcd_stat.ndig - 4'd1) >> 1;
        if (!h_odd_reg)
        begin
            first = bcd_stat.ndig >> 1;
            count = 4'd1;
        end
        else if (sq_stat.extra == 4'd0)
        begin
            first = mid;
            count = 4'd1;
        end
        else
        begin
            first = tl_le_100_reg ? mid : (sq_stat.extra >> 1);
            count = sq_stat.extra;
        end
        plan.first = first;
        plan.last  = first + count;
    end

    dmsk_digit_pick u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_stat.done),
        .digits (bcd_stat.digits),
        .plan   (plan),
        .stat   (pick_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmsk_pkg::ST_IDLE:
            begin
                if (key_end)
                begin
                    state_next = dmsk_pkg::ST_SQUARE;
                end
            end
            dmsk_pkg::ST_SQUARE:
            begin
                if (sq_stat.done)
                begin
                    state_next = dmsk_pkg::ST_CONVERT;
                end
            end
            dmsk_pkg::ST_CONVERT:
            begin
                if (bcd_stat.done)
                begin
                    state_next = dmsk_pkg::ST_PICK;
                end
            end
            dmsk_pkg::ST_PICK:
            begin
                if (pick_stat.done)
                begin
                    state_next = dmsk_pkg::ST_EMIT;
                end
            end
            dmsk_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = dmsk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmsk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (accept)
        begin
            if (in_data.last_byte)
            begin
                sum_next = '0;
                sat_next = 1'b0;
            end
            else
            begin
                sum_next = sum_clamped;
                sat_next = sat_reg || clamp;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmsk_pkg::ST_IDLE;
            tl_reg        <= dmsk_pkg::TL_RESET;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_end)
        begin
            job_sat_reg   <= sat_reg || clamp;
            h_odd_reg     <= sum_clamped[0];
            tl_le_100_reg <= tl_reg <= dmsk_pkg::TL_TWO_DIGIT;
        end
        if (emit_load)
        begin
            out_data_reg.index_value   <= pick_stat.value;
            out_data_reg.sum_saturated <= job_sat_reg;
        end
    end

    assign in_stall  = state_reg != dmsk_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/dmsk_checker.sv -----
// Port-level checker for the mid-square key hash, bound to the top level.
// Depends on dmsk_pkg and the assertion macro header.
`include "decimal_mid_square_key_hash_core_macros.svh"

module dmsk_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  dmsk_pkg::in_word_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  dmsk_pkg::out_word_t            out_data,
    input  logic                           cfg_we,
    input  logic [dmsk_pkg::TL_W-1:0]      cfg_wdata
);

    logic unused_cfg;

    assign unused_cfg = cfg_we ^ (^cfg_wdata);

    // A stalled result word must hold until it is taken.
    `DMSK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Closing a key starts the hash, so the input must stall next cycle.
    `DMSK_ASSERT_NEXT(a_key_end_stalls, clk, rst_n, in_valid && !in_stall && in_data.last_byte, in_stall)

    // A new result appears only at the end of a hash, while input was stalled.
    `DMSK_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // At most nine decimal digits can make up the index.
    `DMSK_ASSERT_SAME(a_index_range, clk, rst_n, out_valid, out_data.index_value <= 30'd999999999)

endmodule

bind decimal_mid_square_key_hash_core dmsk_checker u_dmsk_checker (.*);
